// File: sv/crc16_packet_deframer_assert.svh
// assertion macros shared by the checker
`ifndef CRC16_PACKET_DEFRAMER_ASSERT_SVH
`define CRC16_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cpd_pkg.sv
package cpd_pkg;

    localparam int unsigned MAX_PAYLOAD = 32;
    localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);

    localparam logic [7:0]  START_BYTE  = 8'hA1;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_TYPE,
        ST_LEN,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_DATA,
        ST_READ,
        ST_SEND,
        ST_EMPTY
    } cpd_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_type;
        logic take_len;
        logic take_crc_lo;
        logic take_crc_hi;
        logic take_data;
        logic emit_start;
        logic read;
        logic emit_next;
        logic send_empty;
    } cpd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_hit;
        logic len_too_big;
        logic len_zero;
        logic crc_hi_ok;
        logic data_last;
        logic crc_data_ok;
        logic emit_last;
    } cpd_status_t;

    // reflected ccitt crc, one byte
    function automatic logic [15:0] crc_byte(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] x;
        x = b ^ crc[7:0];
        x = x ^ {x[3:0], 4'b0000};
        return {x, crc[15:8]} ^ {12'h000, x[7:4]} ^ {5'b00000, x, 3'b000};
    endfunction

endpackage

// File: sv/cpd_ctrl.sv
module cpd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    output logic                pkt_valid,
    input  logic                pkt_stall,
    input  cpd_pkg::cpd_status_t status,
    output cpd_pkg::cpd_cmd_t    cmd
);

    cpd_pkg::cpd_state_t state_reg;
    cpd_pkg::cpd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpd_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rx_stall   = 1'b0;
        pkt_valid  = 1'b0;
        case (state_reg)
            cpd_pkg::ST_HUNT:
            begin
                if (rx_valid && status.start_hit)
                begin
                    state_next = cpd_pkg::ST_TYPE;
                end
            end
            cpd_pkg::ST_TYPE:
            begin
                if (rx_valid)
                begin
                    cmd.take_type = 1'b1;
                    state_next    = cpd_pkg::ST_LEN;
                end
            end
            cpd_pkg::ST_LEN:
            begin
                if (rx_valid)
                begin
                    if (status.len_too_big)
                    begin
                        state_next = cpd_pkg::ST_HUNT;
                    end
                    else
                    begin
                        cmd.take_len = 1'b1;
                        state_next   = cpd_pkg::ST_CRC_LO;
                    end
                end
            end
            cpd_pkg::ST_CRC_LO:
            begin
                if (rx_valid)
                begin
                    cmd.take_crc_lo = 1'b1;
                    state_next      = cpd_pkg::ST_CRC_HI;
                end
            end
            cpd_pkg::ST_CRC_HI:
            begin
                if (rx_valid)
                begin
                    cmd.take_crc_hi = 1'b1;
                    if (!status.len_zero)
                    begin
                        state_next = cpd_pkg::ST_DATA;
                    end
                    else if (status.crc_hi_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = cpd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        state_next = cpd_pkg::ST_HUNT;
                    end
                end
            end
            cpd_pkg::ST_DATA:
            begin
                if (rx_valid)
                begin
                    cmd.take_data = 1'b1;
                    if (status.data_last)
                    begin
                        if (status.crc_data_ok)
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = cpd_pkg::ST_READ;
                        end
                        else
                        begin
                            state_next = cpd_pkg::ST_HUNT;
                        end
                    end
                end
            end
            cpd_pkg::ST_READ:
            begin
                rx_stall   = 1'b1;
                cmd.read   = 1'b1;
                state_next = cpd_pkg::ST_SEND;
            end
            cpd_pkg::ST_SEND:
            begin
                rx_stall  = 1'b1;
                pkt_valid = 1'b1;
                if (!pkt_stall)
                begin
                    if (status.emit_last)
                    begin
                        state_next = cpd_pkg::ST_HUNT;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = cpd_pkg::ST_READ;
                    end
                end
            end
            cpd_pkg::ST_EMPTY:
            begin
                rx_stall       = 1'b1;
                pkt_valid      = 1'b1;
                cmd.send_empty = 1'b1;
                if (!pkt_stall)
                begin
                    state_next = cpd_pkg::ST_HUNT;
                end
            end
            default:
            begin
                state_next = cpd_pkg::ST_HUNT;
            end
        endcase
    end

endmodule

// File: sv/cpd_datapath.sv
module cpd_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                rx_byte,
    input  cpd_pkg::cpd_cmd_t         cmd,
    output cpd_pkg::cpd_status_t      status,
    output logic [7:0]                pkt_type,
    output logic [cpd_pkg::LEN_W-1:0] pkt_length,
    output logic                      has_payload,
    output logic [cpd_pkg::IDX_W-1:0] byte_index,
    output logic [7:0]                payload_byte,
    output logic                      last
);

    logic [7:0]                type_reg;
    logic [cpd_pkg::LEN_W-1:0] len_reg;
    logic [7:0]                crc_lo_reg;
    logic [7:0]                crc_hi_reg;
    logic [15:0]               crc_reg;
    logic [15:0]               crc_next;
    logic [cpd_pkg::LEN_W-1:0] count_reg;
    logic [cpd_pkg::IDX_W-1:0] idx_reg;
    logic [7:0]                rd_data_reg;
    logic [7:0]                payload_mem [cpd_pkg::MAX_PAYLOAD];
    logic [cpd_pkg::LEN_W-1:0] count_inc;
    logic [cpd_pkg::LEN_W-1:0] idx_inc;

    assign count_inc = count_reg + cpd_pkg::LEN_W'(1);
    assign idx_inc   = {1'b0, idx_reg} + cpd_pkg::LEN_W'(1);

    // one crc step on the byte at the port
    always_comb
    begin
        if (cmd.take_type)
        begin
            crc_next = cpd_pkg::crc_byte(rx_byte, cpd_pkg::CRC_INIT);
        end
        else
        begin
            crc_next = cpd_pkg::crc_byte(rx_byte, crc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.take_crc_hi)
            begin
                count_reg <= '0;
            end
            else if (cmd.take_data)
            begin
                count_reg <= count_inc;
            end
            if (cmd.emit_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_next)
            begin
                idx_reg <= idx_reg + cpd_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_type)
        begin
            type_reg <= rx_byte;
        end
        if (cmd.take_len)
        begin
            len_reg <= rx_byte[cpd_pkg::LEN_W-1:0];
        end
        if (cmd.take_type || cmd.take_len || cmd.take_data)
        begin
            crc_reg <= crc_next;
        end
        if (cmd.take_crc_lo)
        begin
            crc_lo_reg <= rx_byte;
        end
        if (cmd.take_crc_hi)
        begin
            crc_hi_reg <= rx_byte;
        end
    end

    // payload store
    always_ff @(posedge clk)
    begin
        if (cmd.take_data)
        begin
            payload_mem[count_reg[cpd_pkg::IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.read)
        begin
            rd_data_reg <= payload_mem[idx_reg];
        end
    end

    always_comb
    begin
        status.start_hit   = (rx_byte == cpd_pkg::START_BYTE);
        status.len_too_big = (rx_byte > 8'(cpd_pkg::MAX_PAYLOAD));
        status.len_zero    = (len_reg == '0);
        status.crc_hi_ok   = (crc_reg == {rx_byte, crc_lo_reg});
        status.data_last   = (count_inc >= len_reg);
        status.crc_data_ok = (crc_next == {crc_hi_reg, crc_lo_reg});
        status.emit_last   = (idx_inc == len_reg);
    end

    assign pkt_type     = type_reg;
    assign pkt_length   = len_reg;
    assign has_payload  = !cmd.send_empty;
    assign byte_index   = idx_reg;
    assign payload_byte = cmd.send_empty ? 8'h00 : rd_data_reg;
    assign last         = cmd.send_empty | status.emit_last;

endmodule

// File: sv/crc16_packet_deframer.sv
// channel   direction  handshake            payload
// rx        in         rx_valid / rx_stall  rx_byte
// pkt       out        pkt_valid/pkt_stall  pkt_type, pkt_length, has_payload,
//                                           byte_index, payload_byte, last
// each received byte is taken with rx_valid; the crc is updated as the byte arrives
// a good frame of n payload bytes is sent as n transactions, each a read from the registered
// read port of the payload store and then a send; an empty frame sends one
// rx_stall is high from frame end until the last transaction of the packet goes out
// rst_n is asynchronous, active low, and returns the receiver to hunting
// a stall on pkt holds the result and its fields as they are
module crc16_packet_deframer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_stall,
    input  logic [7:0]                rx_byte,
    output logic                      pkt_valid,
    input  logic                      pkt_stall,
    output logic [7:0]                pkt_type,
    output logic [cpd_pkg::LEN_W-1:0] pkt_length,
    output logic                      has_payload,
    output logic [cpd_pkg::IDX_W-1:0] byte_index,
    output logic [7:0]                payload_byte,
    output logic                      last
);

    // commands from the sequencer and flags back from the datapath
    cpd_pkg::cpd_cmd_t    cmd;
    cpd_pkg::cpd_status_t status;

    // frame sequencer: hunt, header fields, payload, then packet send
    cpd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // header registers, running crc, payload store and result fields
    cpd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .status       (status),
        .pkt_type     (pkt_type),
        .pkt_length   (pkt_length),
        .has_payload  (has_payload),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (last)
    );

endmodule

// File: sv/cpd_checker.sv
`include "crc16_packet_deframer_assert.svh"

module cpd_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rx_stall,
    input logic                      pkt_valid,
    input logic                      pkt_stall,
    input logic [7:0]                pkt_type,
    input logic [cpd_pkg::LEN_W-1:0] pkt_length,
    input logic                      has_payload,
    input logic [cpd_pkg::IDX_W-1:0] byte_index,
    input logic [7:0]                payload_byte,
    input logic                      last
);

    // result fields as one vector and the flags the properties test
    logic [cpd_pkg::LEN_W+cpd_pkg::IDX_W+17:0] pkt_fields;
    logic                                      send_hold;
    logic                                      empty_ok;
    logic                                      index_ok;
    logic [cpd_pkg::LEN_W-1:0]                 idx_ext;
    logic [cpd_pkg::LEN_W-1:0]                 idx_inc;

    assign pkt_fields = {pkt_type, pkt_length, has_payload, byte_index, payload_byte, last};
    assign send_hold  = pkt_valid && pkt_stall;
    assign empty_ok   = last && (byte_index == '0) && (payload_byte == 8'h00)
                        && (pkt_length == '0);
    assign idx_ext    = {1'b0, byte_index};
    assign idx_inc    = idx_ext + cpd_pkg::LEN_W'(1);
    assign index_ok   = (idx_ext < pkt_length) && (last == (idx_inc == pkt_length));

    // a stalled result holds its fields
    `CPD_ASSERT_NEXT(a_pkt_hold, send_hold, pkt_valid && $stable(pkt_fields), "stall moved result")

    // no byte is taken while a packet is being sent
    `CPD_ASSERT_NOW(a_rx_blocked, pkt_valid, rx_stall, "rx open during packet send")

    // an empty packet is a single transaction with zero length, index and payload byte
    `CPD_ASSERT_NOW(a_empty_pkt, pkt_valid && !has_payload, empty_ok, "bad empty packet")

    // index stays inside the length and last marks the final byte
    `CPD_ASSERT_NOW(a_index_range, pkt_valid && has_payload, index_ok, "bad index or last flag")

endmodule

bind crc16_packet_deframer cpd_checker u_cpd_checker (.*);
